FILE: hw/rtl/lnr_pkg.sv
// Package with widths, constants and codes shared by the row normalization block.
package lnr_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int ROW_MAX     = 4096;
   localparam int COUNT_W     = $clog2(ROW_MAX + 1);
   localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
   localparam int SQ_W        = 2 * (SAMPLE_BITS - 1) + COUNT_W + 1;
   localparam int MEAN_W      = 25;
   localparam int SCALE_W     = 25;
   localparam int MUL_W       = 29;
   localparam int DIVN_W      = 56;
   localparam int DIVD_W      = 32;
   localparam int ROOT_W      = 49;
   localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

   typedef enum logic {
      REG_AFFINE = 1'b0,
      REG_EPS    = 1'b1
   } reg_index_type;

   typedef enum logic {
      ACT_STATS = 1'b0,
      ACT_NORM  = 1'b1
   } action_type;
endpackage

FILE: hw/rtl/lnr_req_if.sv
// Input channel interface carrying one sample item.
interface lnr_req_if
   import lnr_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [15:0]            gain;
   logic signed [15:0]            offset;
   logic                          row_end;
   modport source (output valid, action, sample, gain, offset, row_end, input ready);
   modport sink (input valid, action, sample, gain, offset, row_end, output ready);
endinterface

FILE: hw/rtl/lnr_rsp_if.sv
// Result channel interface carrying one normalized item.
interface lnr_rsp_if
   import lnr_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] normalized;
   logic                          clipped;
   logic                          final_res;
   modport source (output valid, normalized, clipped, final_res, input ready);
   modport sink (input valid, normalized, clipped, final_res, output ready);
endinterface

FILE: hw/rtl/lnr_mul.sv
// Shared signed multiplier with a registered product.
module lnr_mul
   import lnr_pkg::*;
   #(parameter int W = MUL_W)
   (
   input  logic                    clock,
   input  logic signed [W-1:0]     a,
   input  logic signed [W-1:0]     b,
   output logic signed [2*W-1:0]   product
   );
   logic signed [2*W-1:0] product_ff;
   always_ff @(posedge clock) begin
      product_ff <= a * b;
   end
   assign product = product_ff;
endmodule

FILE: hw/rtl/lnr_div.sv
// Unsigned restoring divider that retires one quotient bit per cycle.
module lnr_div
   import lnr_pkg::*;
   #(parameter int NW = DIVN_W,
     parameter int DW = DIVD_W)
   (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
   );
   localparam int CW = $clog2(NW + 1);
   logic [CW-1:0] count_ff, count_in;
   logic          done_ff, done_in;
   logic [NW-1:0] quot_ff, quot_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW:0]   rem_sh;
   logic          fits;

   always_comb begin
      rem_sh   = {rem_ff, quot_ff[NW-1]};
      fits     = rem_sh >= {1'b0, div_ff};
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      if (start) begin
         count_in = CW'(NW);
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quot_in  = {quot_ff[NW-2:0], fits};
         rem_in   = fits ? DW'(rem_sh - {1'b0, div_ff}) : rem_sh[DW-1:0];
         done_in  = count_ff == CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

FILE: hw/rtl/lnr_sqrt.sv
// Integer square root that settles two radicand bits per cycle.
module lnr_sqrt
   import lnr_pkg::*;
   #(parameter int W = ROOT_W)
   (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] radicand,
   output logic         done,
   output logic [W-1:0] root
   );
   logic [W-1:0] bit_ff, bit_in;
   logic [W-1:0] val_ff, val_in;
   logic [W:0]   res_ff, res_in;
   logic         done_ff, done_in;
   logic [W:0]   trial;

   always_comb begin
      trial   = res_ff + {1'b0, bit_ff};
      bit_in  = bit_ff;
      val_in  = val_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (start) begin
         bit_in = {1'b1, {(W-1){1'b0}}};
         val_in = radicand;
         res_in = '0;
      end else if (bit_ff != '0) begin
         if ({1'b0, val_ff} >= trial) begin
            val_in = W'({1'b0, val_ff} - trial);
            res_in = (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         done_in = bit_ff[1:0] != 2'b00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff[W-1:0];
endmodule

FILE: hw/rtl/layer_norm_row.sv
// Top level of the two-pass row layer normalization block.
// A statistics item squares and accumulates its sample; the row's last one adds four products,
// three 56-bit divides and a 25-step root, or two divides when variance plus epsilon is zero.
// A normalize item applies gain and offset only when affine is set; an output stall holds it.
// All of this runs through one shared multiplier, one divider and one root unit.
// Synchronous active-high reset clears the statistics and sets the registers to defaults.
module layer_norm_row
   import lnr_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   lnr_req_if.sink     req_ch,
   lnr_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
   );
   typedef enum logic [15:0] {
      S_IDLE = 16'h0001, S_SQ   = 16'h0002, S_ACC  = 16'h0004, F_M1   = 16'h0008,
      F_M2   = 16'h0010, F_M3   = 16'h0020, F_M4   = 16'h0040, F_M5   = 16'h0080,
      F_VAR  = 16'h0100, F_MEAN = 16'h0200, F_RCP  = 16'h0400, F_ROOT = 16'h0800,
      N_M1   = 16'h1000, N_M2   = 16'h2000, N_M3   = 16'h4000, N_OUT  = 16'h8000
   } state_type;

   localparam int PW = 2 * MUL_W;

   state_type                     state_ff, state_in;
   logic                          affine_ff, affine_in;
   logic [15:0]                   eps_ff, eps_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]               sq_ff, sq_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic signed [MEAN_W-1:0]      mean_ff, mean_in;
   logic [SCALE_W-1:0]            inv_ff, inv_in;
   logic                          last_ff, last_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [15:0]            g_ff, g_in;
   logic signed [15:0]            o_ff, o_in;
   logic [DIVN_W-1:0]             num_ff, num_in;
   logic [DIVD_W-1:0]             d_ff, d_in;
   logic signed [49:0]            val_ff, val_in;
   logic                          ovalid_ff, ovalid_in;
   logic signed [SAMPLE_BITS-1:0] onorm_ff, onorm_in;
   logic                          oclip_ff, oclip_in;
   logic                          ofinal_ff, ofinal_in;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PW-1:0]    product;
   logic                    div_start, div_done, root_start, root_done;
   logic [DIVN_W-1:0]       div_num, quotient;
   logic [DIVD_W-1:0]       div_den;
   logic [ROOT_W-1:0]       root;
   logic [COUNT_W-1:0]      n;
   logic [SUM_W-2:0]        mag;
   logic                    neg;
   logic signed [25:0]      diff;
   logic                    cfg_wr;
   logic                    accept;

   lnr_mul #(.W(MUL_W)) u_mul (.clock(clock), .a(mul_a), .b(mul_b), .product(product));

   lnr_div #(.NW(DIVN_W), .DW(DIVD_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(quotient));

   lnr_sqrt #(.W(ROOT_W)) u_sqrt (
      .clock(clock), .reset(reset), .start(root_start), .radicand(quotient[ROOT_W-1:0]),
      .done(root_done), .root(root));

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (reg_index_type'(paddr[2]) == REG_AFFINE) ? {31'b0, affine_ff}
                                                             : {16'b0, eps_ff};
   assign req_ch.ready = state_ff == S_IDLE;
   assign accept = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = ovalid_ff;
   assign rsp_ch.normalized = onorm_ff;
   assign rsp_ch.clipped = oclip_ff;
   assign rsp_ch.final_res = ofinal_ff;

   always_comb begin
      n    = (count_ff == '0) ? COUNT_W'(1) : count_ff;
      neg  = sum_ff[SUM_W-1];
      mag  = neg ? (SUM_W-1)'(-sum_ff) : sum_ff[SUM_W-2:0];
      diff = {{2{x_ff[SAMPLE_BITS-1]}}, x_ff, 8'b0} - {mean_ff[MEAN_W-1], mean_ff};
   end

   always_comb begin
      state_in   = state_ff;
      affine_in  = affine_ff;
      eps_in     = eps_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      count_in   = count_ff;
      mean_in    = mean_ff;
      inv_in     = inv_ff;
      last_in    = last_ff;
      x_in       = x_ff;
      g_in       = g_ff;
      o_in       = o_ff;
      num_in     = num_ff;
      d_in       = d_ff;
      val_in     = val_ff;
      ovalid_in  = ovalid_ff && !rsp_ch.ready;
      onorm_in   = onorm_ff;
      oclip_in   = oclip_ff;
      ofinal_in  = ofinal_ff;
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      div_num    = num_ff;
      div_den    = d_ff;
      root_start = 1'b0;

      if (cfg_wr) begin
         case (reg_index_type'(paddr[2]))
            REG_AFFINE: affine_in = pwdata[0];
            REG_EPS: eps_in = pwdata[15:0];
            default: affine_in = affine_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in    = req_ch.sample;
               g_in    = req_ch.gain;
               o_in    = req_ch.offset;
               last_in = req_ch.row_end;
               if (action_type'(req_ch.action) == ACT_NORM) begin
                  state_in = N_M1;
               end else if (count_ff < COUNT_W'(ROW_MAX)) begin
                  state_in = S_SQ;
               end else if (req_ch.row_end) begin
                  state_in = F_M1;
               end
            end
         end
         S_SQ: begin
            mul_a    = MUL_W'(x_ff);
            mul_b    = MUL_W'(x_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            sum_in   = sum_ff + SUM_W'(x_ff);
            sq_in    = sq_ff + product[SQ_W-1:0];
            count_in = count_ff + 1'b1;
            state_in = last_ff ? F_M1 : S_IDLE;
         end
         F_M1: begin
            mul_a    = MUL_W'({1'b0, n});
            mul_b    = MUL_W'({1'b0, sq_ff[21:0]});
            state_in = F_M2;
         end
         F_M2: begin
            mul_a    = MUL_W'({1'b0, n});
            mul_b    = MUL_W'({1'b0, sq_ff[SQ_W-1:22]});
            num_in   = DIVN_W'(product[PW-2:0]);
            state_in = F_M3;
         end
         F_M3: begin
            mul_a    = MUL_W'({1'b0, mag});
            mul_b    = MUL_W'({1'b0, mag});
            num_in   = num_ff + {product[DIVN_W-23:0], 22'b0};
            state_in = F_M4;
         end
         F_M4: begin
            mul_a    = MUL_W'({1'b0, n});
            mul_b    = MUL_W'({1'b0, n});
            num_in   = num_ff - product[DIVN_W-1:0];
            state_in = F_M5;
         end
         F_M5: begin
            div_start = 1'b1;
            div_num   = num_ff;
            div_den   = product[DIVD_W-1:0];
            state_in  = F_VAR;
         end
         F_VAR: begin
            if (div_done) begin
               d_in      = quotient[DIVD_W-1:0] + {16'b0, eps_ff};
               div_start = 1'b1;
               div_num   = {{(DIVN_W-SUM_W-7){1'b0}}, mag, 8'b0}
                           + (neg ? DIVN_W'(n - 1'b1) : '0);
               div_den   = DIVD_W'(n);
               state_in  = F_MEAN;
            end
         end
         F_MEAN: begin
            if (div_done) begin
               mean_in = neg ? -MEAN_W'({1'b0, quotient[MEAN_W-2:0]})
                             : MEAN_W'({1'b0, quotient[MEAN_W-2:0]});
               if (d_ff == '0) begin
                  inv_in   = SCALE_MAX;
                  sum_in   = '0;
                  sq_in    = '0;
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  div_start = 1'b1;
                  div_num   = DIVN_W'(1) << 48;
                  div_den   = d_ff;
                  state_in  = F_RCP;
               end
            end
         end
         F_RCP: begin
            if (div_done) begin
               root_start = 1'b1;
               state_in   = F_ROOT;
            end
         end
         F_ROOT: begin
            if (root_done) begin
               inv_in   = root[SCALE_W-1:0];
               sum_in   = '0;
               sq_in    = '0;
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         N_M1: begin
            mul_a    = MUL_W'(diff);
            mul_b    = MUL_W'({1'b0, inv_ff});
            state_in = N_M2;
         end
         N_M2: begin
            mul_a  = product[MUL_W+23:24];
            mul_b  = MUL_W'(g_ff);
            val_in = 50'($signed(product[PW-1:24]));
            state_in = affine_ff ? N_M3 : N_OUT;
         end
         N_M3: begin
            val_in   = product[PW-1:8] + 50'(o_ff);
            state_in = N_OUT;
         end
         N_OUT: begin
            if (!ovalid_ff || rsp_ch.ready) begin
               ovalid_in = 1'b1;
               ofinal_in = last_ff;
               if (val_ff > 50'sd32767) begin
                  onorm_in = 16'sh7fff;
                  oclip_in = 1'b1;
               end else if (val_ff < -50'sd32768) begin
                  onorm_in = 16'sh8000;
                  oclip_in = 1'b1;
               end else begin
                  onorm_in = val_ff[SAMPLE_BITS-1:0];
                  oclip_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         affine_ff <= 1'b1;
         eps_ff    <= 16'd1;
         sum_ff    <= '0;
         sq_ff     <= '0;
         count_ff  <= '0;
         mean_ff   <= '0;
         inv_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         affine_ff <= affine_in;
         eps_ff    <= eps_in;
         sum_ff    <= sum_in;
         sq_ff     <= sq_in;
         count_ff  <= count_in;
         mean_ff   <= mean_in;
         inv_ff    <= inv_in;
         ovalid_ff <= ovalid_in;
      end
      last_ff   <= last_in;
      x_ff      <= x_in;
      g_ff      <= g_in;
      o_ff      <= o_in;
      num_ff    <= num_in;
      d_ff      <= d_in;
      val_ff    <= val_in;
      onorm_ff  <= onorm_in;
      oclip_ff  <= oclip_in;
      ofinal_ff <= ofinal_in;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(ROW_MAX))
      else $error("element count exceeds row maximum");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_done)
      else $error("divider finished while the sequencer was idle");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(ovalid_ff) |-> $past(state_ff == N_OUT))
      else $error("result appeared without a normalize item");
   a_root_wait: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == F_ROOT))
      else $error("square root finished outside its wait state");
`endif
endmodule
